[rtl/hamming_sec_codec_assert.svh]
// Assertion macros for the Hamming codec.
// Included by the top level; has no dependencies of its own.
`ifndef HAMMING_SEC_CODEC_ASSERT_SVH
`define HAMMING_SEC_CODEC_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HSC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hamming_sec_codec: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define HSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hamming_sec_codec: next-cycle check failed");

`endif

[rtl/hsc_pkg.sv]
// Shared types, constants and helper functions for the Hamming codec.
// No dependencies; every other file but the assertion header imports this package.
package hsc_pkg;

   // Field widths fixed by the block's interface.
   localparam int WORD_W = 63;
   localparam int SYN_W  = 6;
   localparam int CFG_W  = 6;

   // Reset value of the data length register.
   localparam int RESET_DATA_BITS = 4;

   // Command codes.
   localparam logic CMD_ENCODE = 1'b0;
   localparam logic CMD_DECODE = 1'b1;

   // Code geometry derived from the data length register.
   typedef struct packed {
      logic [SYN_W-1:0]  code_len;
      logic [WORD_W-1:0] mask;
   } hsc_geom_type;

   // One result item.
   typedef struct packed {
      logic [WORD_W-1:0] result_word;
      logic [SYN_W-1:0]  syndrome;
      logic              error_found;
      logic              beyond_length;
   } hsc_result_type;

   // Smallest r with 2^r > m + r.
   function automatic int check_count(input int m);
      int res;
      res = 7;
      for (int r = 7; r >= 1; r--) begin
         if ((2 ** r) > m + r) begin
            res = r;
         end
      end
      return res;
   endfunction

   // Largest data length whose codeword fits in max_n bits.
   function automatic int max_data_bits(input int max_n);
      int res;
      res = 1;
      for (int m = 1; m < 64; m++) begin
         if (m + check_count(m) <= max_n) begin
            res = m;
         end
      end
      return res;
   endfunction

   // Codeword length for a raw register value, with zero read as one
   // and large values clamped to max_m.
   function automatic int code_length(input int m_raw, input int max_m);
      int m;
      m = m_raw;
      if (m == 0) begin
         m = 1;
      end
      if (m > max_m) begin
         m = max_m;
      end
      return m + check_count(m);
   endfunction

endpackage

[rtl/hsc_req_if.sv]
// Request channel: command and input word with valid/ready handshake.
// Depends on hsc_pkg for the word width.
interface hsc_req_if import hsc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              command;
   logic [WORD_W-1:0] data_word;

   modport source (output valid, command, data_word, input ready);
   modport sink   (input valid, command, data_word, output ready);
endinterface

[rtl/hsc_rsp_if.sv]
// Response channel: result word and decode status with valid/ready handshake.
// Depends on hsc_pkg for the field widths.
interface hsc_rsp_if import hsc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] result_word;
   logic [SYN_W-1:0]  syndrome;
   logic              error_found;
   logic              beyond_length;

   modport source (output valid, result_word, syndrome, error_found, beyond_length,
                   input ready);
   modport sink   (input valid, result_word, syndrome, error_found, beyond_length,
                   output ready);
endinterface

[rtl/hsc_csr_if.sv]
// Configuration write channel carrying the data length register.
// Depends on hsc_pkg for the register width.
interface hsc_csr_if import hsc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CFG_W-1:0] data_bits;

   modport source (output valid, data_bits, input ready);
   modport sink   (input valid, data_bits, output ready);
endinterface

[rtl/hsc_cfg.sv]
// Data length register; holds the derived codeword length and bit mask.
// Depends on hsc_pkg and hsc_csr_if.
module hsc_cfg
   import hsc_pkg::*;
#(
   parameter int MAX_CODE_BITS = 63
) (
   input  logic          clock,
   input  logic          reset,
   hsc_csr_if.sink       csr_chan,
   output hsc_geom_type  geom
);

   localparam int MaxM     = max_data_bits(MAX_CODE_BITS);
   localparam int ResetLen = code_length(RESET_DATA_BITS, MaxM);

   logic [SYN_W-1:0]  code_len_ff, code_len_in;
   logic [WORD_W-1:0] mask_ff, mask_in;

   // Writes are always taken.
   assign csr_chan.ready = 1'b1;

   // Work out the codeword length and its mask from the written value.
   always_comb begin
      code_len_in = SYN_W'(code_length(int'(csr_chan.data_bits), MaxM));
      for (int i = 0; i < WORD_W; i++) begin
         mask_in[i] = SYN_W'(i) < code_len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_len_ff <= SYN_W'(ResetLen);
         for (int i = 0; i < WORD_W; i++) begin
            mask_ff[i] <= i < ResetLen;
         end
      end else if (csr_chan.valid) begin
         code_len_ff <= code_len_in;
         mask_ff     <= mask_in;
      end
   end

   assign geom.code_len = code_len_ff;
   assign geom.mask     = mask_ff;

endmodule

[rtl/hsc_datapath.sv]
// Combinational encode and decode of one word: scatter, parity trees,
// syndrome and single-bit correction. Depends on hsc_pkg.
module hsc_datapath
   import hsc_pkg::*;
(
   input  logic              command,
   input  logic [WORD_W-1:0] data_word,
   input  hsc_geom_type      geom,
   output hsc_result_type    result
);

   // Each syndrome bit is the parity of all positions that have that bit set.
   function automatic logic [SYN_W-1:0] syndrome_of(input logic [WORD_W-1:0] w);
      logic [SYN_W-1:0] s;
      s = '0;
      for (int k = 0; k < SYN_W; k++) begin
         for (int p = 1; p <= WORD_W; p++) begin
            if (((p >> k) & 1) == 1) begin
               s[k] = s[k] ^ w[p-1];
            end
         end
      end
      return s;
   endfunction

   logic [WORD_W-1:0] scattered;
   logic [WORD_W-1:0] enc_word;
   logic [SYN_W-1:0]  enc_syn;
   logic [WORD_W-1:0] dec_in;
   logic [SYN_W-1:0]  dec_syn;
   logic [WORD_W-1:0] flip;
   logic              dec_beyond;
   logic              dec_error;

   // Place data bits at the non-power-of-two positions; bits past the data
   // length land beyond the codeword and are masked off.
   always_comb begin
      int b;
      b = 0;
      scattered = '0;
      for (int p = 1; p <= WORD_W; p++) begin
         if ((p & (p - 1)) != 0) begin
            scattered[p-1] = data_word[b];
            b++;
         end
      end
      scattered = scattered & geom.mask;
   end

   // Encode: the syndrome of the data-only word gives the check bits.
   always_comb begin
      enc_syn  = syndrome_of(scattered);
      enc_word = scattered;
      for (int k = 0; k < SYN_W; k++) begin
         enc_word[(2 ** k) - 1] = enc_syn[k];
      end
      enc_word = enc_word & geom.mask;
   end

   // Decode: syndrome of the received word, flip the named position unless
   // it lies past the codeword.
   always_comb begin
      dec_in     = data_word & geom.mask;
      dec_syn    = syndrome_of(dec_in);
      dec_error  = dec_syn != '0;
      dec_beyond = dec_syn > geom.code_len;
      for (int i = 0; i < WORD_W; i++) begin
         flip[i] = dec_syn == SYN_W'(i + 1);
      end
      if (!dec_error || dec_beyond) begin
         flip = '0;
      end
   end

   // Select the result for the command.
   always_comb begin
      if (command == CMD_DECODE) begin
         result.result_word   = (dec_in ^ flip) & geom.mask;
         result.syndrome      = dec_syn;
         result.error_found   = dec_error;
         result.beyond_length = dec_beyond;
      end else begin
         result.result_word   = enc_word;
         result.syndrome      = '0;
         result.error_found   = 1'b0;
         result.beyond_length = 1'b0;
      end
   end

endmodule

[rtl/hamming_sec_codec.sv]
// Top level of the Hamming single-error-correcting codec.
// Depends on hsc_pkg, the channel interfaces, hsc_cfg, hsc_datapath and
// hamming_sec_codec_assert.svh.
//
// The codec encodes or checks one word per cycle while responses are taken.
// A request transfer is captured in an input register, encoded or decoded by
// XOR parity trees in a single stage, and held in a result register; a new
// request can be taken every cycle unless both registers are full and the
// response is not taken; the parity trees of that one stage set the clock. While a response waits,
// one more request is still taken into the input register. The data length
// register (csr) may be written only while no request is in flight; zero is
// read as one data bit and lengths whose codeword would exceed
// MAX_CODE_BITS are clamped to the longest that fits.
module hamming_sec_codec
   import hsc_pkg::*;
#(
   parameter int MAX_CODE_BITS = 63
) (
   input  logic      clock,
   input  logic      reset,
   hsc_req_if.sink   req_chan,
   hsc_rsp_if.source rsp_chan,
   hsc_csr_if.sink   csr_chan
);

`include "hamming_sec_codec_assert.svh"

   hsc_geom_type      geom;
   hsc_result_type    stage_result;

   logic              in_valid_ff, in_valid_in;
   logic              in_command_ff;
   logic [WORD_W-1:0] in_word_ff;
   logic              out_valid_ff, out_valid_in;
   hsc_result_type    out_result_ff;
   logic              out_ready;
   logic              in_ready;

   hsc_cfg #(
      .MAX_CODE_BITS (MAX_CODE_BITS)
   ) u_cfg (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .geom     (geom)
   );

   hsc_datapath u_datapath (
      .command   (in_command_ff),
      .data_word (in_word_ff),
      .geom      (geom),
      .result    (stage_result)
   );

   // Each stage moves on when the one after it has room.
   assign out_ready      = !out_valid_ff || rsp_chan.ready;
   assign in_ready       = !in_valid_ff || out_ready;
   assign req_chan.ready = in_ready;

   always_comb begin
      in_valid_in  = in_ready ? req_chan.valid : in_valid_ff;
      out_valid_in = out_ready ? in_valid_ff : out_valid_ff;
   end

   // Stage valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers load on a transfer into their stage.
   always_ff @(posedge clock) begin
      if (in_ready && req_chan.valid) begin
         in_command_ff <= req_chan.command;
         in_word_ff    <= req_chan.data_word;
      end
      if (out_ready && in_valid_ff) begin
         out_result_ff <= stage_result;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.result_word   = out_result_ff.result_word;
   assign rsp_chan.syndrome      = out_result_ff.syndrome;
   assign rsp_chan.error_found   = out_result_ff.error_found;
   assign rsp_chan.beyond_length = out_result_ff.beyond_length;

   // A request transfer always fills the input stage.
   `HSC_ASSERT_NEXT(a_req_fills, clock, reset, req_chan.valid && req_chan.ready, in_valid_ff)
   // A word in the input stage moves to the result stage when it has room.
   `HSC_ASSERT_NEXT(a_stage_moves, clock, reset, in_valid_ff && out_ready, out_valid_ff)
   // An encode never reports a syndrome or an error.
   `HSC_ASSERT_NEXT(a_encode_clean, clock, reset,
      in_valid_ff && out_ready && (in_command_ff == CMD_ENCODE),
      (out_result_ff.syndrome == '0) && !out_result_ff.error_found &&
      !out_result_ff.beyond_length)
   // No result bit is set past the codeword length.
   `HSC_ASSERT_SAME(a_masked, clock, reset, out_valid_ff,
      (out_result_ff.result_word & ~geom.mask) == '0)

endmodule

[verif/tb.sv]
// Self-checking testbench for the Hamming single-error-correcting codec.
// Depends on hsc_pkg, the three channel interfaces and hamming_sec_codec.
// Directed rows come first, then random phases with varied lengths and idling.
module tb;
   import hsc_pkg::*;

   localparam int CODE_LIMIT  = 63;
   localparam int STALL_LIMIT = 4000;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASES      = 10;
   localparam int PHASE_ITEMS = 100;
   localparam int PRINT_LIMIT = 100;

   // One row of the directed stimulus.
   typedef struct {
      logic [CFG_W-1:0]  len;
      logic              cmd;
      logic [WORD_W-1:0] word;
      bit                fixed;
      hsc_result_type    want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   hsc_req_if req_if ();
   hsc_rsp_if rsp_if ();
   hsc_csr_if csr_if ();

   hamming_sec_codec u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   always #10 clock = ~clock;

   hsc_result_type   pending_results[$];
   stim_row_type     stim_rows[$];
   logic [CFG_W-1:0] len_shadow = CFG_W'(RESET_DATA_BITS);

   int send_idle_pct    = 34;
   int recv_idle_pct    = 48;
   int holdoff_requests = 0;
   int holdoff_served   = 0;
   int hold_left        = 0;
   int quiet_cycles     = 0;
   int mismatches       = 0;
   int results_seen     = 0;
   int encodes          = 0;
   int decodes          = 0;
   int corrected        = 0;
   int past_word        = 0;
   int len_writes       = 0;

   // Number of check bits r: the smallest value with 2^r > m + r.
   function automatic int parity_count(input int m);
      int r;
      r = 1;
      while ((1 << r) <= m + r) begin
         r++;
      end
      return r;
   endfunction

   // Codeword length for a register value; zero reads as one data bit and
   // lengths that overflow the word are lowered until the codeword fits.
   function automatic int code_len(input logic [CFG_W-1:0] len_reg);
      int m;
      m = (len_reg == 0) ? 1 : int'(len_reg);
      while (m > 1 && m + parity_count(m) > CODE_LIMIT) begin
         m--;
      end
      return m + parity_count(m);
   endfunction

   // XOR of the positions of all set bits within the first n positions.
   function automatic int syndrome_of(input logic [WORD_W-1:0] cw, input int n);
      int s;
      s = 0;
      for (int p = 1; p <= n; p++) begin
         if (cw[p-1]) begin
            s = s ^ p;
         end
      end
      return s;
   endfunction

   // Expected result of one request under the given length register.
   function automatic hsc_result_type hamming_predict(input logic cmd,
                                                      input logic [WORD_W-1:0] word,
                                                      input logic [CFG_W-1:0] len_reg);
      hsc_result_type    res;
      logic [WORD_W-1:0] cw;
      logic [WORD_W-1:0] mask;
      int                n;
      int                b;
      int                s;
      int                p;
      res  = '0;
      n    = code_len(len_reg);
      mask = '0;
      for (p = 0; p < n; p++) begin
         mask[p] = 1'b1;
      end
      if (cmd == CMD_ENCODE) begin
         // Data bits fill the non-power-of-two positions in order.
         cw = '0;
         b  = 0;
         for (p = 1; p <= n; p++) begin
            if ((p & (p - 1)) != 0) begin
               cw[p-1] = word[b];
               b++;
            end
         end
         // Setting the check bits named by the data syndrome zeroes it.
         s = syndrome_of(cw, n);
         for (p = 1; p <= n; p = p * 2) begin
            if ((s & p) != 0) begin
               cw[p-1] = 1'b1;
            end
         end
         res.result_word = cw;
      end else begin
         cw = word & mask;
         s  = syndrome_of(cw, n);
         res.syndrome      = s[SYN_W-1:0];
         res.error_found   = (s != 0);
         res.beyond_length = (s > n);
         if (s != 0 && s <= n) begin
            cw[s-1] = ~cw[s-1];
         end
         res.result_word = cw;
      end
      return res;
   endfunction

   task automatic report_mismatch(input string field, input logic [WORD_W-1:0] got,
                                  input logic [WORD_W-1:0] want);
      mismatches++;
      if (mismatches <= PRINT_LIMIT) begin
         $display("MISMATCH result %0d %s: got %h, expected %h",
                  results_seen, field, got, want);
      end
   endtask

   task automatic add_row(input logic [CFG_W-1:0] len, input logic cmd,
                          input logic [WORD_W-1:0] word, input bit fixed,
                          input logic [WORD_W-1:0] rword, input logic [SYN_W-1:0] syn,
                          input logic err, input logic beyond);
      stim_row_type row;
      row.len                = len;
      row.cmd                = cmd;
      row.word               = word;
      row.fixed              = fixed;
      row.want.result_word   = rword;
      row.want.syndrome      = syn;
      row.want.error_found   = err;
      row.want.beyond_length = beyond;
      stim_rows.push_back(row);
   endtask

   // Offer one request after a random gap and record what it should produce.
   task automatic send_item(input logic cmd, input logic [WORD_W-1:0] word,
                            input bit fixed, input hsc_result_type want);
      hsc_result_type pred;
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.command   <= cmd;
      req_if.data_word <= word;
      @(posedge clock);
      while (!req_if.ready) begin
         @(posedge clock);
      end
      pred = fixed ? want : hamming_predict(cmd, word, len_shadow);
      if (cmd == CMD_ENCODE) begin
         encodes++;
      end else begin
         decodes++;
      end
      if (pred.beyond_length) begin
         past_word++;
      end else if (pred.error_found) begin
         corrected++;
      end
      pending_results.push_back(pred);
   endtask

   // Stop offering and wait until every outstanding result has arrived.
   task automatic drain();
      req_if.valid <= 1'b0;
      while (pending_results.size() != 0) begin
         @(posedge clock);
      end
      @(posedge clock);
   endtask

   // Length register write, only with the codec idle.
   task automatic write_len(input logic [CFG_W-1:0] value);
      drain();
      csr_if.valid     <= 1'b1;
      csr_if.data_bits <= value;
      @(posedge clock);
      while (!csr_if.ready) begin
         @(posedge clock);
      end
      len_shadow = value;
      len_writes++;
      csr_if.valid <= 1'b0;
   endtask

   // Encodes of raw noise, codewords with zero, one or two flipped bits, and raw noise to decode.
   task automatic random_item(output logic cmd, output logic [WORD_W-1:0] word);
      hsc_result_type    enc;
      logic [WORD_W-1:0] noise;
      int                sel;
      int                n;
      int                flips;
      int                pos;
      sel   = $urandom_range(99);
      noise = WORD_W'({$urandom, $urandom});
      n     = code_len(len_shadow);
      if (sel < 35) begin
         cmd  = CMD_ENCODE;
         word = noise;
      end else if (sel < 80) begin
         cmd   = CMD_DECODE;
         enc   = hamming_predict(CMD_ENCODE, WORD_W'({$urandom, $urandom}), len_shadow);
         word  = enc.result_word;
         flips = ($urandom_range(99) < 25) ? 0 : (($urandom_range(99) < 80) ? 1 : 2);
         for (int i = 0; i < flips; i++) begin
            pos       = $urandom_range(n - 1);
            word[pos] = ~word[pos];
         end
         // Garbage above the codeword must be ignored.
         if ($urandom_range(4) == 0) begin
            word = word | (noise << n);
         end
      end else begin
         cmd  = CMD_DECODE;
         word = noise;
      end
   endtask

   // Result side: check each transfer, then pick ready for the next cycle.
   always @(posedge clock) begin
      hsc_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result_word", rsp_if.result_word, '0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_if.result_word !== want.result_word)
               report_mismatch("result_word", rsp_if.result_word, want.result_word);
            if (rsp_if.syndrome !== want.syndrome)
               report_mismatch("syndrome", WORD_W'(rsp_if.syndrome),
                               WORD_W'(want.syndrome));
            if (rsp_if.error_found !== want.error_found)
               report_mismatch("error_found", WORD_W'(rsp_if.error_found),
                               WORD_W'(want.error_found));
            if (rsp_if.beyond_length !== want.beyond_length)
               report_mismatch("beyond_length", WORD_W'(rsp_if.beyond_length),
                               WORD_W'(want.beyond_length));
         end
      end
      if (holdoff_served != holdoff_requests) begin
         hold_left      = HOLD_CYCLES;
         holdoff_served = holdoff_requests;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog: end the run if no transfer happens for too long.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results pending",
                     quiet_cycles, pending_results.size());
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   initial begin
      logic             cmd;
      logic [WORD_W-1:0] word;
      hsc_result_type   none;
      logic [CFG_W-1:0] phase_len [PHASES];
      int               ph;
      int               k;
      phase_len = '{6'd5, 6'd57, 6'd1, 6'd0, 6'd63, 6'd26, 6'd11, 6'd2, 6'd57, 6'd0};
      none      = '0;
      req_if.valid     <= 1'b0;
      req_if.command   <= CMD_ENCODE;
      req_if.data_word <= '0;
      csr_if.valid     <= 1'b0;
      csr_if.data_bits <= '0;

      // Directed rows: length, command, word, then the typed result if any.
      add_row(6'd4,  CMD_ENCODE, 63'h0, 1'b1, 63'h0, 6'd0, 1'b0, 1'b0);
      add_row(6'd4,  CMD_ENCODE, 63'hF, 1'b1, 63'h7F, 6'd0, 1'b0, 1'b0);
      add_row(6'd4,  CMD_ENCODE, 63'h7FFF_FFFF_FFFF_FFF0, 1'b1, 63'h0, 6'd0, 1'b0, 1'b0);
      add_row(6'd4,  CMD_DECODE, 63'h7F, 1'b1, 63'h7F, 6'd0, 1'b0, 1'b0);
      add_row(6'd4,  CMD_DECODE, 63'h7E, 1'b1, 63'h7F, 6'd1, 1'b1, 1'b0);
      add_row(6'd4,  CMD_DECODE, 63'h40, 1'b1, 63'h0, 6'd7, 1'b1, 1'b0);
      add_row(6'd4,  CMD_DECODE, 63'h7FFF_FFFF_FFFF_FFFF, 1'b1, 63'h7F, 6'd0, 1'b0, 1'b0);
      add_row(6'd4,  CMD_ENCODE, 63'h5, 1'b0, 63'h0, 6'd0, 1'b0, 1'b0);
      add_row(6'd4,  CMD_DECODE, 63'h33, 1'b0, 63'h0, 6'd0, 1'b0, 1'b0);
      // One data bit, then a zero length that reads as one.
      add_row(6'd1,  CMD_ENCODE, 63'h1, 1'b1, 63'h7, 6'd0, 1'b0, 1'b0);
      add_row(6'd1,  CMD_DECODE, 63'h4, 1'b1, 63'h0, 6'd3, 1'b1, 1'b0);
      add_row(6'd0,  CMD_ENCODE, 63'h1, 1'b1, 63'h7, 6'd0, 1'b0, 1'b0);
      add_row(6'd0,  CMD_DECODE, 63'h7, 1'b1, 63'h7, 6'd0, 1'b0, 1'b0);
      // Syndromes past the codeword, and one that names its last position.
      add_row(6'd2,  CMD_DECODE, 63'hA, 1'b1, 63'hA, 6'd6, 1'b1, 1'b1);
      add_row(6'd2,  CMD_ENCODE, 63'h3, 1'b0, 63'h0, 6'd0, 1'b0, 1'b0);
      add_row(6'd5,  CMD_DECODE, 63'h82, 1'b1, 63'h82, 6'd10, 1'b1, 1'b1);
      add_row(6'd5,  CMD_DECODE, 63'h100, 1'b1, 63'h0, 6'd9, 1'b1, 1'b0);
      // Full 63-bit codeword, then lengths that must be clamped.
      add_row(6'd57, CMD_ENCODE, 63'h7FFF_FFFF_FFFF_FFFF, 1'b1, 63'h7FFF_FFFF_FFFF_FFFF,
              6'd0, 1'b0, 1'b0);
      add_row(6'd57, CMD_DECODE, 63'h7FFF_FFFF_FFFF_FFFF, 1'b1, 63'h7FFF_FFFF_FFFF_FFFF,
              6'd0, 1'b0, 1'b0);
      add_row(6'd57, CMD_DECODE, 63'h4000_0000_0000_0000, 1'b1, 63'h0, 6'd63, 1'b1, 1'b0);
      add_row(6'd57, CMD_ENCODE, 63'h0155_5555_5555_5555, 1'b0, 63'h0, 6'd0, 1'b0, 1'b0);
      add_row(6'd57, CMD_DECODE, 63'h2AAA_AAAA_AAAA_AAAA, 1'b0, 63'h0, 6'd0, 1'b0, 1'b0);
      add_row(6'd63, CMD_ENCODE, 63'h7FFF_FFFF_FFFF_FFFF, 1'b1, 63'h7FFF_FFFF_FFFF_FFFF,
              6'd0, 1'b0, 1'b0);
      add_row(6'd63, CMD_DECODE, 63'h1, 1'b1, 63'h0, 6'd1, 1'b1, 1'b0);
      add_row(6'd58, CMD_ENCODE, 63'h1234_5678_9ABC_DEF0, 1'b0, 63'h0, 6'd0, 1'b0, 1'b0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_rows[i]) begin
         if (stim_rows[i].len != len_shadow) begin
            write_len(stim_rows[i].len);
         end
         send_item(stim_rows[i].cmd, stim_rows[i].word, stim_rows[i].fixed,
                   stim_rows[i].want);
      end

      // Random phases: a new length each phase, idling swapped then removed.
      for (ph = 0; ph < PHASES; ph++) begin
         if (ph == 4) begin
            send_idle_pct = 48;
            recv_idle_pct = 34;
         end else if (ph == 7) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         write_len((ph == PHASES - 1) ? CFG_W'($urandom_range(63)) : phase_len[ph]);
         for (k = 0; k < PHASE_ITEMS; k++) begin
            // Long result stall with the sender still pushing.
            if (ph == 7 && k == 20) begin
               holdoff_requests++;
            end
            random_item(cmd, word);
            send_item(cmd, word, 1'b0, none);
         end
      end

      drain();
      repeat (8) @(posedge clock);

      $display("covered %0d encodes and %0d decodes: %0d single-bit corrections,",
               encodes, decodes, corrected);
      $display("%0d syndromes past the codeword, %0d length writes, %0d results checked",
               past_word, len_writes, results_seen);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
